@@ design/tca_pkg.sv @@
// ----------------------------------------------------------------------------
// tca_pkg: shared types and constants for the triangle corner angle block
// Word formats, case codes, cell states and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package tca_pkg;

  // number of CORDIC rotations and how many of them are used
  localparam int CORDIC_STAGES = 20;
  localparam int CORDIC_USED   = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;

  // fixed angles, 16 fractional bits
  localparam logic [17:0] ANGLE_PI       = 18'd205887;
  localparam logic [17:0] ANGLE_PI_THIRD = 18'd68629;

  // epsilon after reset
  localparam logic [15:0] EPS_RESET = 16'd7;

  // case codes
  typedef enum logic [1:0] {
    CASE_NORMAL    = 2'd0,
    CASE_ZERO_PERI = 2'd1,
    CASE_FLAT      = 2'd2
  } case_code_t;

  // input word: three corners, Q16.16
  typedef struct packed {
    logic signed [31:0] corner_a_x;
    logic signed [31:0] corner_a_y;
    logic signed [31:0] corner_a_z;
    logic signed [31:0] corner_b_x;
    logic signed [31:0] corner_b_y;
    logic signed [31:0] corner_b_z;
    logic signed [31:0] corner_c_x;
    logic signed [31:0] corner_c_y;
    logic signed [31:0] corner_c_z;
  } in_word_t;

  // result word
  typedef struct packed {
    logic [17:0] angle;
    logic [1:0]  case_code;
  } out_word_t;

  // square root cell state: remainder and partial root
  typedef struct packed {
    logic [127:0] rem;
    logic [63:0]  root;
  } sqrt_state_t;

  // cordic cell state
  typedef struct packed {
    logic signed [63:0] x;
    logic signed [63:0] y;
    logic signed [33:0] z;
  } cordic_state_t;

  // atan(2^-i) in Q30
  localparam logic [29:0] ATAN_Q30 [32] = '{
    30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
    30'd33543516, 30'd16775851, 30'd8388437, 30'd4194283, 30'd2097149,
    30'd1048576, 30'd524288, 30'd262144, 30'd131072, 30'd65536, 30'd32768,
    30'd16384, 30'd8192, 30'd4096, 30'd2048, 30'd1024, 30'd512, 30'd256,
    30'd128, 30'd64, 30'd32, 30'd16, 30'd8, 30'd4, 30'd2, 30'd1, 30'd0
  };

  function automatic logic signed [33:0] atan_q30(input logic [4:0] idx);
    return signed'({4'b0, ATAN_Q30[idx]});
  endfunction

endpackage

@@ design/tca_sqrt_cell.sv @@
// ----------------------------------------------------------------------------
// tca_sqrt_cell: one bit of a restoring square root
// Tries one root bit against the remainder and hands the state onward.
// ----------------------------------------------------------------------------
module tca_sqrt_cell (
  input  logic                 clk,
  input  logic [5:0]           bit_idx,
  input  tca_pkg::sqrt_state_t st_in,
  output tca_pkg::sqrt_state_t st_r
);
  import tca_pkg::*;

  logic [127:0] trial;
  sqrt_state_t  st_nxt;

  // (root + 2^i)^2 - root^2 against remainder
  always_comb begin
    trial  = (128'(st_in.root) << ({1'b0, bit_idx} + 7'd1))
           + (128'(1) << {bit_idx, 1'b0});
    st_nxt = st_in;
    if (st_in.rem >= trial) begin
      st_nxt.rem  = st_in.rem - trial;
      st_nxt.root = st_in.root | (64'(1) << bit_idx);
    end
  end

  always_ff @(posedge clk) begin
    st_r <= st_nxt;
  end

endmodule

@@ design/tca_cordic_cell.sv @@
// ----------------------------------------------------------------------------
// tca_cordic_cell: one vectoring CORDIC rotation
// Rotates toward the x axis and accumulates the arctangent in Q30.
// ----------------------------------------------------------------------------
module tca_cordic_cell (
  input  logic                   clk,
  input  logic [4:0]             stage_idx,
  input  tca_pkg::cordic_state_t st_in,
  output tca_pkg::cordic_state_t st_r
);
  import tca_pkg::*;

  cordic_state_t st_nxt;

  // direction from sign of y
  always_comb begin
    if (!st_in.y[63]) begin
      st_nxt.x = st_in.x + (st_in.y >>> stage_idx);
      st_nxt.y = st_in.y - (st_in.x >>> stage_idx);
      st_nxt.z = st_in.z + atan_q30(stage_idx);
    end else begin
      st_nxt.x = st_in.x - (st_in.y >>> stage_idx);
      st_nxt.y = st_in.y + (st_in.x >>> stage_idx);
      st_nxt.z = st_in.z - atan_q30(stage_idx);
    end
  end

  always_ff @(posedge clk) begin
    st_r <= st_nxt;
  end

endmodule

@@ design/triangle_corner_angle_3d_top.sv @@
// ----------------------------------------------------------------------------
// triangle_corner_angle_3d_top: interior angle at corner a of a 3D triangle
// Side lengths by root cells, half-angle formula, CORDIC arctangent.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with one word of three Q16.16 corners on in_word. busy is
//   always low, so a word is taken at every clock edge where start is high:
//   one triangle per cycle, sustained.
//   Each result appears on out_word for one cycle with out_valid high
//   after its word was taken. Between the two lie registers for the
//   differences, squares and sums, 33 root cells for the sides, registers
//   for terms, product halves and products, six normalizing steps, 61
//   root cells for the radicands, one cell per CORDIC rotation and an
//   output register.
//   Results come out in input order; the receiver cannot stall and must
//   take each result in its cycle.
//   cfg_we with cfg_wdata writes epsilon; write it only while no word is in
//   flight. Reset sets epsilon to 7 and clears every valid flag in the
//   pipeline; no clearing pass is needed.
// ----------------------------------------------------------------------------
module triangle_corner_angle_3d_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  tca_pkg::in_word_t  in_word,
  output logic               out_valid,
  output tca_pkg::out_word_t out_word,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata
);
  import tca_pkg::*;

  localparam int SIDE_CELLS = 33;
  localparam int ROOT_CELLS = 61;
  localparam int NORM_STEPS = 6;
  localparam int LAT  = 3 + SIDE_CELLS + 3 + NORM_STEPS + ROOT_CELLS + CORDIC_USED + 1;
  localparam int TAGL = NORM_STEPS + ROOT_CELLS + CORDIC_USED;

  logic in_accept;
  assign busy      = 1'b0;
  assign in_accept = start && !busy;

  // epsilon register
  logic [15:0] eps_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r <= EPS_RESET;
    end else if (cfg_we) begin
      eps_r <= cfg_wdata;
    end
  end

  // valid line through the whole pipeline
  logic [LAT-1:0] vld_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LAT-2:0], in_accept};
    end
  end

  // absolute coordinate differences: side a = c-b, b = a-c, c = b-a
  logic signed [32:0] dif [3][3];
  logic [32:0]        abs_r [3][3];
  always_comb begin
    dif[0][0] = 33'(in_word.corner_c_x) - 33'(in_word.corner_b_x);
    dif[0][1] = 33'(in_word.corner_c_y) - 33'(in_word.corner_b_y);
    dif[0][2] = 33'(in_word.corner_c_z) - 33'(in_word.corner_b_z);
    dif[1][0] = 33'(in_word.corner_a_x) - 33'(in_word.corner_c_x);
    dif[1][1] = 33'(in_word.corner_a_y) - 33'(in_word.corner_c_y);
    dif[1][2] = 33'(in_word.corner_a_z) - 33'(in_word.corner_c_z);
    dif[2][0] = 33'(in_word.corner_b_x) - 33'(in_word.corner_a_x);
    dif[2][1] = 33'(in_word.corner_b_y) - 33'(in_word.corner_a_y);
    dif[2][2] = 33'(in_word.corner_b_z) - 33'(in_word.corner_a_z);
  end

  logic [65:0] sq_r [3][3];
  logic [65:0] sum_r [3];
  always_ff @(posedge clk) begin
    for (int s = 0; s < 3; s++) begin
      for (int k = 0; k < 3; k++) begin
        abs_r[s][k] <= dif[s][k][32] ? 33'(-dif[s][k]) : 33'(dif[s][k]);
        sq_r[s][k]  <= abs_r[s][k] * abs_r[s][k];
      end
      sum_r[s] <= sq_r[s][0] + sq_r[s][1] + sq_r[s][2];
    end
  end

  // side length root chains
  sqrt_state_t side_st [3][SIDE_CELLS];
  for (genvar s = 0; s < 3; s++) begin : g_side
    for (genvar k = 0; k < SIDE_CELLS; k++) begin : g_cell
      sqrt_state_t src;
      if (k == 0) begin : g_first
        assign src = '{rem: 128'(sum_r[s]), root: '0};
      end else begin : g_next
        assign src = side_st[s][k-1];
      end
      tca_sqrt_cell u_cell (
        .clk     (clk),
        .bit_idx (6'(SIDE_CELLS - 1 - k)),
        .st_in   (src),
        .st_r    (side_st[s][k])
      );
    end
  end

  // doubled terms and degenerate cases
  logic signed [35:0] sa, sb, sc, tw, tt, tu, tv, eps2, abs_t;
  case_code_t         kind_c;
  always_comb begin
    sa    = signed'({3'b0, side_st[0][SIDE_CELLS-1].root[32:0]});
    sb    = signed'({3'b0, side_st[1][SIDE_CELLS-1].root[32:0]});
    sc    = signed'({3'b0, side_st[2][SIDE_CELLS-1].root[32:0]});
    tw    = sa + sb + sc;
    tt    = sb + sc - sa;
    tu    = sa + sc - sb;
    tv    = sa + sb - sc;
    eps2  = signed'({19'b0, eps_r, 1'b0});
    abs_t = tt[35] ? -tt : tt;
    priority if (tw <= eps2) begin
      kind_c = CASE_ZERO_PERI;
    end else if (abs_t <= eps2) begin
      kind_c = CASE_FLAT;
    end else begin
      kind_c = CASE_NORMAL;
    end
  end

  logic [34:0] u_r, v_r, w_r, t_r;
  case_code_t  kind_c_r, kind_p1_r, kind_p2_r;
  always_ff @(posedge clk) begin
    u_r      <= tu[35] ? '0 : tu[34:0];
    v_r      <= tv[35] ? '0 : tv[34:0];
    t_r      <= tt[35] ? '0 : tt[34:0];
    w_r      <= tw[34:0];
    kind_c_r <= kind_c;
  end

  // products in two halves, then summed
  logic [52:0] nl_r, dl_r;
  logic [51:0] nh_r, dh_r;
  logic        zero_p1_r, zero_p2_r;
  logic [69:0] n_r, d_r;
  always_ff @(posedge clk) begin
    nl_r      <= u_r[17:0] * v_r;
    nh_r      <= u_r[34:18] * v_r;
    dl_r      <= w_r[17:0] * t_r;
    dh_r      <= w_r[34:18] * t_r;
    zero_p1_r <= (u_r == '0 || v_r == '0) && (w_r == '0 || t_r == '0);
    kind_p1_r <= kind_c_r;
    n_r       <= 70'(nl_r) + (70'(nh_r) << 18);
    d_r       <= 70'(dl_r) + (70'(dh_r) << 18);
    zero_p2_r <= zero_p1_r;
    kind_p2_r <= kind_p1_r;
  end

  // normalizing steps: even left shifts keeping the pair below 2^121
  logic [120:0] nrm_n_r [NORM_STEPS];
  logic [120:0] nrm_d_r [NORM_STEPS];
  for (genvar j = 0; j < NORM_STEPS; j++) begin : g_norm
    localparam int SH = 64 >> j;
    logic [120:0] src_n, src_d, m_or;
    if (j == 0) begin : g_first
      assign src_n = 121'(n_r);
      assign src_d = 121'(d_r);
    end else begin : g_next
      assign src_n = nrm_n_r[j-1];
      assign src_d = nrm_d_r[j-1];
    end
    assign m_or = src_n | src_d;
    always_ff @(posedge clk) begin
      if (m_or[120 -: SH] == '0) begin
        nrm_n_r[j] <= src_n << SH;
        nrm_d_r[j] <= src_d << SH;
      end else begin
        nrm_n_r[j] <= src_n;
        nrm_d_r[j] <= src_d;
      end
    end
  end

  // radicand root chains
  sqrt_state_t rn_st [ROOT_CELLS];
  sqrt_state_t rd_st [ROOT_CELLS];
  for (genvar k = 0; k < ROOT_CELLS; k++) begin : g_root
    sqrt_state_t src_n, src_d;
    if (k == 0) begin : g_first
      assign src_n = '{rem: 128'(nrm_n_r[NORM_STEPS-1]), root: '0};
      assign src_d = '{rem: 128'(nrm_d_r[NORM_STEPS-1]), root: '0};
    end else begin : g_next
      assign src_n = rn_st[k-1];
      assign src_d = rd_st[k-1];
    end
    tca_sqrt_cell u_cell_n (
      .clk     (clk),
      .bit_idx (6'(ROOT_CELLS - 1 - k)),
      .st_in   (src_n),
      .st_r    (rn_st[k])
    );
    tca_sqrt_cell u_cell_d (
      .clk     (clk),
      .bit_idx (6'(ROOT_CELLS - 1 - k)),
      .st_in   (src_d),
      .st_r    (rd_st[k])
    );
  end

  // cordic rotation chain
  cordic_state_t cd_st [CORDIC_USED];
  for (genvar k = 0; k < CORDIC_USED; k++) begin : g_cordic
    cordic_state_t src;
    if (k == 0) begin : g_first
      assign src.x = signed'({3'b0, rd_st[ROOT_CELLS-1].root[60:0]});
      assign src.y = signed'({3'b0, rn_st[ROOT_CELLS-1].root[60:0]});
      assign src.z = '0;
    end else begin : g_next
      assign src = cd_st[k-1];
    end
    tca_cordic_cell u_cell (
      .clk       (clk),
      .stage_idx (5'(k)),
      .st_in     (src),
      .st_r      (cd_st[k])
    );
  end

  // case tag line alongside normalize, root and cordic cells
  logic [2:0] tag_r [TAGL];
  always_ff @(posedge clk) begin
    tag_r[0] <= {kind_p2_r, zero_p2_r};
    for (int i = 1; i < TAGL; i++) begin
      tag_r[i] <= tag_r[i-1];
    end
  end

  // angle rounding, clamp and case override
  logic signed [33:0] zsum, qv;
  case_code_t         kind_f;
  out_word_t          out_nxt, out_word_r;
  always_comb begin
    zsum   = {cd_st[CORDIC_USED-1].z[32:0], 1'b0} + 34'sd8192;
    qv     = zsum >>> 14;
    kind_f = case_code_t'(tag_r[TAGL-1][2:1]);
    out_nxt.case_code = kind_f;
    unique case (kind_f)
      CASE_ZERO_PERI: out_nxt.angle = ANGLE_PI_THIRD;
      CASE_FLAT:      out_nxt.angle = ANGLE_PI;
      default: begin
        priority if (tag_r[TAGL-1][0] || qv < 0) begin
          out_nxt.angle = '0;
        end else if (qv > signed'({16'b0, ANGLE_PI})) begin
          out_nxt.angle = ANGLE_PI;
        end else begin
          out_nxt.angle = qv[17:0];
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_nxt;
  end

  assign out_word  = out_word_r;
  assign out_valid = vld_r[LAT-1];

  // checks
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |-> ##LAT out_valid)
    else $error("result missing after pipeline latency");
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_accept, LAT))
    else $error("result without a matching input word");
  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_word.angle <= ANGLE_PI))
    else $error("angle above pi");
  a_peri_angle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.case_code == CASE_ZERO_PERI)
      |-> (out_word.angle == ANGLE_PI_THIRD))
    else $error("zero perimeter case without pi/3");

endmodule
